/* rtl/chol_pkg.sv */
// Package for the Cholesky factor block: sizes, fixed-point constants, types.
// No dependencies.
package chol_pkg;
  localparam int MaxN = 8;
  localparam int FracBits = 16;
  localparam int IdxW = 3;
  localparam int AddrW = 6;
  localparam int DataW = 32;
  localparam logic [1:0] RegMatrixSize = 2'd0;
  localparam logic [1:0] RegMinPivot = 2'd1;
  typedef logic signed [DataW-1:0] word_t;
endpackage

/* rtl/chol_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module chol_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/chol_divsqrt.sv */
// Iterative unit: 64-bit integer square root or unsigned 64/32 division,
// one bit per cycle. Depends on chol_pkg.
module chol_divsqrt
  import chol_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_sqrt,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo,
  output logic [63:0] rem
);
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [127:0] dvd;
  logic [6:0] cnt;
  logic busy;
  logic sq;
  logic [31:0] d;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sq <= is_sqrt;
        v <= num;
        r <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        dvd <= {64'd0, num};
        d <= den;
        cnt <= 7'd64;
      end else if (busy) begin
        if (sq) begin
          if (bitv == 64'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
            quo <= r;
            rem <= v;
          end else begin
            if (v >= r + bitv) begin
              v <= v - (r + bitv);
              r <= (r >> 1) + bitv;
            end else begin
              r <= r >> 1;
            end
            bitv <= bitv >> 2;
          end
        end else begin
          if (cnt == 7'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
            quo <= dvd[63:0];
            rem <= dvd[127:64];
          end else begin
            cnt <= cnt - 7'd1;
            if (dvd[127] == 1'b0 && {dvd[126:63]} >= {32'd0, d}) begin
              dvd <= {dvd[126:63] - {32'd0, d}, dvd[62:0], 1'b1};
            end else begin
              dvd <= {dvd[126:0], 1'b0};
            end
          end
        end
      end
    end
  end
`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("start not taken");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy after done");
`endif
endmodule

/* rtl/cholesky_lower_factor.sv */
// Lower Cholesky factor of an n by n Q16.16 matrix, n = 1..8.
// Loads: one transfer per cycle while busy is low; the store is one RAM.
// Factor run after last: per entry an A read and i multiply-accumulates, then a
// root or a divide through the shared iterative unit; then n*n results, which
// cannot stall, or a single failure result at a pivot not above min_pivot.
// Reset (rst, synchronous): registers to 8 and 0, idle; store contents undefined.
module cholesky_lower_factor
  import chol_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [IdxW-1:0]    row,
  input  logic [IdxW-1:0]    col,
  input  logic signed [31:0] value,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               strobe,
  output logic [IdxW-1:0]    out_row,
  output logic [IdxW-1:0]    out_col,
  output logic signed [31:0] out_value,
  output logic               status,
  output logic [IdxW-1:0]    fail_index,
  output logic               out_last
);
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_INITW, S_RDA, S_RDB, S_MAC, S_ROOT, S_ROOTW,
    S_DIV, S_DIVW, S_EMIT, S_EMITW
  } state_t;

  state_t state;
  logic [3:0] matrix_size;
  logic [30:0] min_pivot;
  logic [IdxW:0] n;
  logic [IdxW-1:0] i, j, k, er, ec;
  logic signed [63:0] acc;
  logic signed [31:0] la;
  logic signed [31:0] lii;
  // A is kept in store A; L goes into a second RAM.
  logic a_we, l_we;
  logic [AddrW-1:0] a_waddr, a_raddr, l_waddr, l_raddr;
  logic [31:0] a_wdata, l_wdata, a_rdata, l_rdata;
  logic signed [63:0] prod;
  logic signed [64:0] diff;
  logic signed [63:0] acc_sub;
  logic du_start, du_sqrt, du_done;
  logic [63:0] du_num, du_quo, du_rem;
  logic [63:0] mag;
  logic neg;
  logic [63:0] q_rnd;
  logic signed [31:0] sat_v;
  logic [63:0] thr;
  logic du_sqrt_r;

  chol_ram #(.Width(DataW), .Depth(MaxN*MaxN)) u_a (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata));
  chol_ram #(.Width(DataW), .Depth(MaxN*MaxN)) u_l (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata));
  chol_divsqrt u_du (
    .clk, .rst, .start(du_start), .is_sqrt(du_sqrt), .num(du_num), .den(lii),
    .done(du_done), .quo(du_quo), .rem(du_rem));

  assign busy = (state != S_IDLE);
  assign a_we = start && !busy;
  assign a_waddr = {row, col};
  assign a_wdata = value;
  assign prod = 64'(la) * 64'(signed'(l_rdata));
  assign diff = {acc[63], acc} - {prod[63], prod};
  always_comb begin
    if (diff[64] != diff[63]) acc_sub = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else acc_sub = diff[63:0];
  end
  assign mag = acc[63] ? (64'd0 - acc) : acc;
  assign neg = acc[63];
  assign thr = {17'd0, min_pivot, 16'd0};
  // Rounding/saturation of the failing pivot.
  always_comb begin
    q_rnd = (mag + 64'(1 << (FracBits-1))) >> FracBits;
    if (neg) sat_v = (q_rnd >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q_rnd);
    else sat_v = (q_rnd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q_rnd[31:0];
  end

  // Read addresses: A(i,j) during init, L(i,k) then L(j,k) in the MAC loop, L(er,ec) on emit.
  always_comb begin
    a_raddr = {i, j};
    l_raddr = {i, k};
    if (state == S_RDB || state == S_MAC) l_raddr = {j, k};
    if (state == S_EMIT || state == S_EMITW) l_raddr = {er, ec};
  end

  logic [63:0] dq_adj;
  logic [31:0] res_v;
  always_comb begin
    // Root: round to nearest, ties down. Divide: round half away via rem.
    dq_adj = du_quo;
    if (du_sqrt_r) begin
      if (du_rem > du_quo) dq_adj = du_quo + 64'd1;
    end else if ({du_rem[62:0], 1'b0} >= {32'd0, lii}) begin
      dq_adj = du_quo + 64'd1;
    end
    if (du_sqrt_r) res_v = (dq_adj > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq_adj[31:0];
    else if (neg) res_v = (dq_adj >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - dq_adj);
    else res_v = (dq_adj > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq_adj[31:0];
  end
  assign du_sqrt = (state == S_ROOT);
  assign du_start = (state == S_ROOT) || (state == S_DIV);
  assign du_num = mag;
  assign l_we = du_done;
  assign l_waddr = du_sqrt_r ? {i, i} : {j, i};
  assign l_wdata = res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      matrix_size <= 4'd8;
      min_pivot <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == RegMatrixSize) matrix_size <= cfg_data[3:0];
        else if (cfg_index == RegMinPivot) min_pivot <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start && last) begin
            n <= (matrix_size == 4'd0) ? 4'd1 : (matrix_size > 4'd8) ? 4'd8 : matrix_size;
            i <= '0;
            j <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          k <= '0;
          state <= S_INITW;
        end
        S_INITW: begin
          acc <= 64'(signed'(a_rdata)) <<< FracBits;
          state <= (i == 3'd0) ? (i == j ? S_ROOT : S_DIV) : S_RDA;
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          la <= l_rdata;
          state <= S_MAC;
        end
        S_MAC: begin
          acc <= acc_sub;
          if (k == i - 3'd1) begin
            state <= (i == j) ? S_ROOT : S_DIV;
          end else begin
            k <= k + 3'd1;
            state <= S_RDA;
          end
        end
        S_ROOT: begin
          du_sqrt_r <= 1'b1;
          if (acc <= $signed(thr)) begin
            strobe <= 1'b1;
            out_row <= i;
            out_col <= i;
            out_value <= sat_v;
            status <= 1'b1;
            fail_index <= i;
            out_last <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_ROOTW;
          end
        end
        S_DIV: begin
          du_sqrt_r <= 1'b0;
          state <= S_DIVW;
        end
        S_ROOTW, S_DIVW: begin
          if (du_done) begin
            if (du_sqrt_r) lii <= res_v;
            if ({1'b0, j} == n - 4'd1) begin
              if ({1'b0, i} == n - 4'd1) begin
                er <= '0;
                ec <= '0;
                state <= S_EMIT;
              end else begin
                i <= i + 3'd1;
                j <= i + 3'd1;
                state <= S_INIT;
              end
            end else begin
              j <= j + 3'd1;
              state <= S_INIT;
            end
          end
        end
        S_EMIT: state <= S_EMITW;
        S_EMITW: begin
          strobe <= 1'b1;
          out_row <= er;
          out_col <= ec;
          out_value <= (ec <= er) ? l_rdata : 32'sd0;
          status <= 1'b0;
          fail_index <= '0;
          out_last <= ({1'b0, er} == n - 4'd1) && ({1'b0, ec} == n - 4'd1);
          if ({1'b0, ec} == n - 4'd1) begin
            ec <= '0;
            if ({1'b0, er} == n - 4'd1) state <= S_IDLE;
            else begin
              er <= er + 3'd1;
              state <= S_EMIT;
            end
          end else begin
            ec <= ec + 3'd1;
            state <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
`ifndef SYNTH
  a_no_strobe_idle_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe || $past(last)) else $error("result during load");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && out_last) |-> state == S_IDLE) else $error("run not ended");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> out_last) else $error("failure not last");
`endif
endmodule
